// ===== design/akvt_pkg.sv =====
// Shared types and constants for the associative key/value table.
package akvt_pkg;

    localparam int ENTRIES_DEF    = 8;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    // Fixed port field widths
    localparam int OPCODE_W = 2;
    localparam int STATUS_W = 2;
    localparam int FIELD_W  = 32;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SET = 2'd0,
        OP_GET = 2'd1,
        OP_DEL = 2'd2,
        OP_NOP = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    // Control part of the request token walking the cell chain
    typedef struct packed {
        logic    valid;
        opcode_t op;
        logic    hit;
        logic    free_found;
    } tok_ctrl_t;

endpackage

// ===== design/akvt_cell.sv =====
// One table slot: holds valid/key/value and processes the passing request token.
module akvt_cell
    import akvt_pkg::*;
#(
    parameter int INDEX      = 0,
    parameter int IDX_W      = 3,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // token from previous cell
    input  tok_ctrl_t             ctrl_in,
    input  logic [KEY_BITS-1:0]   key_in,
    input  logic [VALUE_BITS-1:0] val_in,
    input  logic [VALUE_BITS-1:0] rd_in,
    input  logic [IDX_W-1:0]      idx_in,
    // token to next cell
    output tok_ctrl_t             ctrl_out,
    output logic [KEY_BITS-1:0]   key_out,
    output logic [VALUE_BITS-1:0] val_out,
    output logic [VALUE_BITS-1:0] rd_out,
    output logic [IDX_W-1:0]      idx_out,
    // deferred insert, broadcast to all cells
    input  logic                  ins_we,
    input  logic [IDX_W-1:0]      ins_idx,
    input  logic [KEY_BITS-1:0]   ins_key,
    input  logic [VALUE_BITS-1:0] ins_val,
    output logic                  slot_valid
);

    logic                  valid_reg, valid_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;

    tok_ctrl_t             ctrl_reg, ctrl_next;
    logic [KEY_BITS-1:0]   tkey_reg, tkey_next;
    logic [VALUE_BITS-1:0] tval_reg, tval_next;
    logic [VALUE_BITS-1:0] rd_reg, rd_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;

    logic                  match;

    always_comb
    begin
        match      = valid_reg && (key_reg == key_in) && !ctrl_in.hit;
        valid_next = valid_reg;
        key_next   = key_reg;
        value_next = value_reg;
        ctrl_next  = ctrl_reg;
        tkey_next  = tkey_reg;
        tval_next  = tval_reg;
        rd_next    = rd_reg;
        idx_next   = idx_reg;

        ctrl_next.valid = 1'b0;

        if (ctrl_in.valid)
        begin
            ctrl_next = ctrl_in;
            tkey_next = key_in;
            tval_next = val_in;
            rd_next   = rd_in;
            idx_next  = idx_in;

            if (match)
            begin
                ctrl_next.hit = 1'b1;
                unique case (ctrl_in.op)
                    OP_SET:  value_next = val_in;
                    OP_GET:  rd_next    = value_reg;
                    OP_DEL:  valid_next = 1'b0;
                    default: ;
                endcase
            end

            // first empty slot seen on the walk
            if (!valid_reg && !ctrl_in.free_found)
            begin
                ctrl_next.free_found = 1'b1;
                idx_next             = IDX_W'(INDEX);
            end
        end

        if (ins_we && (ins_idx == IDX_W'(INDEX)))
        begin
            valid_next = 1'b1;
            key_next   = ins_key;
            value_next = ins_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            ctrl_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            ctrl_reg  <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
        tkey_reg  <= tkey_next;
        tval_reg  <= tval_next;
        rd_reg    <= rd_next;
        idx_reg   <= idx_next;
    end

    assign ctrl_out   = ctrl_reg;
    assign key_out    = tkey_reg;
    assign val_out    = tval_reg;
    assign rd_out     = rd_reg;
    assign idx_out    = idx_reg;
    assign slot_valid = valid_reg;

endmodule

// ===== design/assoc_key_value_table_unit.sv =====
// Top level of the fully associative key/value table built as a chain of slot cells.
//
//  channel   dir  tdata                              tuser
//  s_axis    in   [31:0] lookup_key, [63:32] write_value   [1:0] opcode
//  m_axis    out  [31:0] read_value                 [1:0] status
//
// Flow: a request walks the chain one cell per cycle, then passes through the finish
// stage into the output register. The walk through the cell chain sets the rate: one
// request in flight at a time.
// A finished result waits in the output register while the next request is taken.
// Reset: all slots empty; keys and values are undefined until written.
// Stalls: a held-off result keeps the finish stage (and with it s_axis_tready) low.
module assoc_key_value_table_unit
    import akvt_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [2*FIELD_W-1:0]          s_axis_tdata,  // lookup_key, write_value
    input  logic [OPCODE_W-1:0]           s_axis_tuser,  // opcode
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [FIELD_W-1:0]            m_axis_tdata,  // read_value
    output logic [STATUS_W-1:0]           m_axis_tuser   // status
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // token links between cells; link 0 is the accepted beat
    tok_ctrl_t             ctrl_w [ENTRIES+1];
    logic [KEY_BITS-1:0]   key_w  [ENTRIES+1];
    logic [VALUE_BITS-1:0] val_w  [ENTRIES+1];
    logic [VALUE_BITS-1:0] rd_w   [ENTRIES+1];
    logic [IDX_W-1:0]      idx_w  [ENTRIES+1];

    logic [ENTRIES-1:0]    slot_valid;

    logic                  busy_reg, busy_next;
    logic                  done_valid_reg, done_valid_next;
    logic                  out_valid_reg, out_valid_next;
    status_t               out_status_reg, out_status_next;
    logic [FIELD_W-1:0]    out_data_reg, out_data_next;

    logic                  accept;
    logic                  finish;
    logic                  ins_we;
    status_t               fin_status;
    logic [FIELD_W-1:0]    fin_data;
    tok_ctrl_t             last;

    assign s_axis_tready = !busy_reg && !done_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign ctrl_w[0].valid      = accept;
    assign ctrl_w[0].op         = opcode_t'(s_axis_tuser);
    assign ctrl_w[0].hit        = 1'b0;
    assign ctrl_w[0].free_found = 1'b0;
    assign key_w[0] = KEY_BITS'(s_axis_tdata[FIELD_W-1:0]);
    assign val_w[0] = VALUE_BITS'(s_axis_tdata[2*FIELD_W-1:FIELD_W]);
    assign rd_w[0]  = '0;
    assign idx_w[0] = '0;

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        akvt_cell #(
            .INDEX      (g),
            .IDX_W      (IDX_W),
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl_in    (ctrl_w[g]),
            .key_in     (key_w[g]),
            .val_in     (val_w[g]),
            .rd_in      (rd_w[g]),
            .idx_in     (idx_w[g]),
            .ctrl_out   (ctrl_w[g+1]),
            .key_out    (key_w[g+1]),
            .val_out    (val_w[g+1]),
            .rd_out     (rd_w[g+1]),
            .idx_out    (idx_w[g+1]),
            .ins_we     (ins_we),
            .ins_idx    (idx_w[ENTRIES]),
            .ins_key    (key_w[ENTRIES]),
            .ins_val    (val_w[ENTRIES]),
            .slot_valid (slot_valid[g])
        );
    end

    // The last cell holds its token fields until the next request enters,
    // so the finish stage reads them directly.
    assign last   = ctrl_w[ENTRIES];
    assign finish = done_valid_reg && (!out_valid_reg || m_axis_tready);

    // Result of the walk; a set with no match claims the first free slot seen.
    always_comb
    begin
        fin_status = ST_OK;
        fin_data   = '0;
        ins_we     = 1'b0;
        unique case (last.op)
            OP_SET:
            begin
                if (!last.hit)
                begin
                    if (last.free_found)
                        ins_we = finish;
                    else
                        fin_status = ST_FULL;
                end
            end
            OP_GET:
            begin
                if (last.hit)
                    fin_data = FIELD_W'(rd_w[ENTRIES]);
                else
                    fin_status = ST_ABSENT;
            end
            OP_DEL:
            begin
                if (!last.hit)
                    fin_status = ST_ABSENT;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        busy_next       = busy_reg;
        done_valid_next = done_valid_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;

        if (accept)
            busy_next = 1'b1;
        if (last.valid)
        begin
            busy_next       = 1'b0;
            done_valid_next = 1'b1;
        end

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        if (finish)
        begin
            done_valid_next = 1'b0;
            out_valid_next  = 1'b1;
            out_status_next = fin_status;
            out_data_next   = fin_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            done_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            done_valid_reg <= done_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

    // at most one request in the chain or the finish stage
    a_single_flight: assert property (@(posedge clk) disable iff (!rst_n)
        done_valid_reg |-> !busy_reg)
        else $error("finish stage and chain both occupied");

    // an accepted request occupies the chain next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy_reg || done_valid_reg))
        else $error("accepted request lost");

    // table full is only reported when every slot is valid
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && (fin_status == ST_FULL)) |-> (&slot_valid))
        else $error("table full reported with a free slot");

    // an insert marks its slot valid
    a_insert_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ins_we |=> slot_valid[$past(idx_w[ENTRIES])])
        else $error("inserted slot not valid");

endmodule
